/* src/dfq_pkg.sv */
// dfq_pkg: shared sizes, codes and types for the duplicate-rejecting queue.
// No dependencies; used by every file in src.
`default_nettype none

package dfq_pkg;

  // Queue geometry
  localparam int DEPTH     = 16;
  localparam int ITEM_BITS = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Fixed field widths of the stream words
  localparam int VALUE_FIELD_W = 32;
  localparam int COUNT_FIELD_W = 5;
  localparam int STATUS_W      = 2;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 40;
  localparam int OUT_PAD_W     = OUT_DATA_W - VALUE_FIELD_W - COUNT_FIELD_W;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Per-cell control: shift pulls from the upper neighbor, load takes the new value
  typedef struct packed {
    logic shift;
    logic load;
  } ctrl_t;

endpackage

`default_nettype wire

/* src/dedup_fifo_queue.sv */
// dedup_fifo_queue: top level, a row of dfq_cell slots plus control and result register.
// Depends on dfq_pkg and dfq_cell.
`default_nettype none

// A first-in first-out queue of DEPTH nonzero handles that refuses duplicates.
// Each input word is an insert (tuser 0, handle in tdata) or a remove
// (tuser 1). Every input word yields exactly one output word: status in
// tuser (ok, null/duplicate rejected, full, empty), popped handle in
// tdata[31:0] (zero unless a remove succeeded) and the count after the
// operation in tdata[36:32]. The slots form a row of cells with the head in
// cell 0: an insert loads the cell at the current count, a remove shifts
// every cell down by one toward the head. Each cell compares its contents to
// the incoming handle, so the duplicate check is one OR across the row.
// One word is taken per clock while the result register can take it; the result
// is registered, and input is taken whenever that register is empty or is being
// drained in the same cycle, so back-to-back traffic runs at one word per
// clock with no bubbles. Reset (rst, synchronous) empties the queue.

module dedup_fifo_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input words
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [dfq_pkg::IN_DATA_W-1:0] s_tdata,   // [31:0] item_value
  input  wire logic [0:0]                    s_tuser,   // [0] operation
  // result words
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [dfq_pkg::OUT_DATA_W-1:0]     m_tdata,   // [31:0] popped_value,
                                                        // [36:32] entry_count, rest 0
  output logic [dfq_pkg::STATUS_W-1:0]       m_tuser    // [1:0] status
);

  // Row state
  logic [dfq_pkg::ITEM_BITS-1:0] cell_value [dfq_pkg::DEPTH];
  logic                          cell_valid [dfq_pkg::DEPTH];
  logic [dfq_pkg::DEPTH-1:0]     cell_match;
  dfq_pkg::ctrl_t                cell_ctrl  [dfq_pkg::DEPTH];

  logic [dfq_pkg::CNT_W-1:0]     count;
  logic [dfq_pkg::CNT_W-1:0]     count_next;

  // Result register
  dfq_pkg::status_t                  res_status;
  logic [dfq_pkg::VALUE_FIELD_W-1:0] res_popped;
  logic [dfq_pkg::COUNT_FIELD_W-1:0] res_count;

  // Decode of the current word
  logic                          accept;
  dfq_pkg::op_t                  op;
  logic [dfq_pkg::ITEM_BITS-1:0] in_value;
  logic                          is_dup;
  logic                          is_full;
  logic                          is_empty;
  logic                          do_insert;
  logic                          do_remove;
  dfq_pkg::status_t              status_next;
  logic [dfq_pkg::VALUE_FIELD_W-1:0] popped_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = dfq_pkg::op_t'(s_tuser[0]);
  assign in_value = dfq_pkg::ITEM_BITS'(s_tdata);

  assign is_dup   = |cell_match;
  assign is_full  = (count == dfq_pkg::CNT_W'(dfq_pkg::DEPTH));
  assign is_empty = (count == '0);

  // Status priority: null/duplicate before full
  always_comb begin
    status_next = dfq_pkg::ST_OK;
    popped_next = '0;
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    unique case (op)
      dfq_pkg::OP_INSERT: begin
        priority if (in_value == '0 || is_dup) begin
          status_next = dfq_pkg::ST_REJECT;
        end else if (is_full) begin
          status_next = dfq_pkg::ST_FULL;
        end else begin
          do_insert = accept;
        end
      end
      dfq_pkg::OP_REMOVE: begin
        if (is_empty) begin
          status_next = dfq_pkg::ST_EMPTY;
        end else begin
          popped_next = dfq_pkg::VALUE_FIELD_W'(cell_value[0]);
          do_remove   = accept;
        end
      end
      default: begin
        status_next = dfq_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    priority if (do_insert) begin
      count_next = count + dfq_pkg::CNT_W'(1);
    end else if (do_remove) begin
      count_next = count - dfq_pkg::CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Cell row: cell 0 is the head; the top cell pulls in an empty slot on a shift
  for (genvar i = 0; i < dfq_pkg::DEPTH; i++) begin : g_cell
    logic [dfq_pkg::ITEM_BITS-1:0] up_value;
    logic                          up_valid;

    if (i == dfq_pkg::DEPTH - 1) begin : g_top
      assign up_value = '0;
      assign up_valid = 1'b0;
    end else begin : g_mid
      assign up_value = cell_value[i+1];
      assign up_valid = cell_valid[i+1];
    end

    assign cell_ctrl[i].shift = do_remove;
    assign cell_ctrl[i].load  = do_insert && (count == dfq_pkg::CNT_W'(i));

    dfq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl[i]),
      .up_value  (up_value),
      .up_valid  (up_valid),
      .new_value (in_value),
      .value     (cell_value[i]),
      .valid     (cell_valid[i]),
      .match     (cell_match[i])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= status_next;
      res_popped <= popped_next;
      res_count  <= dfq_pkg::COUNT_FIELD_W'(count_next);
    end
  end

  assign m_tdata = {{dfq_pkg::OUT_PAD_W{1'b0}}, res_count, res_popped};
  assign m_tuser = res_status;

endmodule

`default_nettype wire

/* src/dfq_cell.sv */
// dfq_cell: one queue slot with its valid bit and its own equality compare.
// Depends on dfq_pkg.
`default_nettype none

module dfq_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dfq_pkg::ctrl_t                ctrl,
  input  wire logic [dfq_pkg::ITEM_BITS-1:0] up_value,  // from upper neighbor
  input  wire logic                          up_valid,
  input  wire logic [dfq_pkg::ITEM_BITS-1:0] new_value, // insert / compare value
  output logic      [dfq_pkg::ITEM_BITS-1:0] value,
  output logic                               valid,
  output logic                               match
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= up_value;
    end else if (ctrl.load) begin
      value <= new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= up_valid;
    end else if (ctrl.load) begin
      valid <= 1'b1;
    end
  end

  assign match = valid && (value == new_value);

endmodule

`default_nettype wire

/* src/dfq_checker.sv */
// dfq_checker: port-level assertions for dedup_fifo_queue, bound to the top level.
// Depends on dfq_pkg and dedup_fifo_queue.
`default_nettype none

module dfq_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic [dfq_pkg::IN_DATA_W-1:0] s_tdata,
  input wire logic [0:0]                    s_tuser,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [dfq_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic [dfq_pkg::STATUS_W-1:0]  m_tuser
);

  logic [dfq_pkg::COUNT_FIELD_W-1:0] out_count;
  logic [dfq_pkg::VALUE_FIELD_W-1:0] out_popped;

  assign out_count  = m_tdata[dfq_pkg::VALUE_FIELD_W +: dfq_pkg::COUNT_FIELD_W];
  assign out_popped = m_tdata[dfq_pkg::VALUE_FIELD_W-1:0];

  // Stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // No new word taken while the result register is blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result stalled");

  // Count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_count <= dfq_pkg::COUNT_FIELD_W'(dfq_pkg::DEPTH))
    else $error("count above depth");

  // Full and empty reports agree with the count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == dfq_pkg::ST_FULL |->
      out_count == dfq_pkg::COUNT_FIELD_W'(dfq_pkg::DEPTH) && out_popped == '0)
    else $error("full status with count below depth");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == dfq_pkg::ST_EMPTY |-> out_count == '0 && out_popped == '0)
    else $error("empty status with nonzero count or value");

endmodule

bind dedup_fifo_queue dfq_checker u_dfq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

/* sim/tb.sv */
// tb: self-checking bench for dedup_fifo_queue. Covers inserts, removes, null, duplicate,
// full and empty cases under random stalls on both stream sides. Depends on dfq_pkg and dedup_fifo_queue.
`timescale 1ns / 100ps

module tb;
  import dfq_pkg::*;

  // one expected result word
  typedef struct {
    status_t            status;
    logic [31:0]        popped;
    logic [4:0]         count;
  } queue_result_t;

  localparam int HOLD_LEN = 80;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [31:0] item_value
  logic [0:0]            s_tuser = '0;   // [0] operation
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [31:0] popped_value, [36:32] entry_count
  logic [STATUS_W-1:0]   m_tuser;        // [1:0] status

  // shadow of the handles held, head at index 0
  logic [31:0]   held_handles[$];
  queue_result_t results_due[$];
  int            err_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_left = 0;
  // hold-off requests from the tests, served by the receiver process
  int            hold_requests = 0;
  int            hold_served = 0;

  dedup_fifo_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predict one queue operation and update the shadow queue.
  function automatic queue_result_t apply_queue_op(op_t op, logic [31:0] raw);
    queue_result_t r;
    logic [31:0]   handle;
    bit            seen;
    handle = raw;
    if (ITEM_BITS < 32) handle = raw & ((32'h1 << ITEM_BITS) - 32'h1);
    r.status = ST_OK;
    r.popped = '0;
    if (op == OP_INSERT) begin
      seen = 1'b0;
      foreach (held_handles[i]) if (held_handles[i] == handle) seen = 1'b1;
      // duplicate check wins over full
      if (handle == '0 || seen) r.status = ST_REJECT;
      else if (held_handles.size() >= DEPTH) r.status = ST_FULL;
      else held_handles.push_back(handle);
    end else if (held_handles.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.popped = held_handles.pop_front();
    end
    r.count = 5'(held_handles.size());
    return r;
  endfunction

  // Offer one word; predict at the edge where it is taken.
  // tvalid stays high after acceptance until the next falling edge.
  task automatic send_word(op_t op, logic [31:0] handle);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= handle;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    results_due.push_back(apply_queue_op(op, handle));
  endtask

  // Drop tvalid so a stale word is not taken again during a pause.
  task automatic sender_rest();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a counted hold-off on request.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_LEN - 1;
      m_tready    <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: compare each taken word with the oldest prediction.
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        $error("result word with nothing pending: status %0d tdata %h", m_tuser, m_tdata);
        err_count++;
      end else begin
        want = results_due.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          err_count++;
        end
        if (m_tdata[31:0] !== want.popped) begin
          $error("popped_value: expected %h, got %h", want.popped, m_tdata[31:0]);
          err_count++;
        end
        if (m_tdata[36:32] !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, m_tdata[36:32]);
          err_count++;
        end
      end
    end
  end

  // Corner cases: empty remove, null, duplicates, fill to full, full with dup/null, refill.
  task automatic test_directed();
    send_word(OP_REMOVE, 32'hDEAD_BEEF);
    send_word(OP_INSERT, 32'h0000_0000);
    send_word(OP_INSERT, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'h0000_0001);
    for (int k = 0; k < DEPTH - 2; k++) send_word(OP_INSERT, 32'h8000_0000 >> k);
    send_word(OP_INSERT, 32'h1234_5678);  // full
    send_word(OP_INSERT, 32'h0000_0001);  // duplicate while full
    send_word(OP_INSERT, 32'h0000_0000);  // null while full
    send_word(OP_REMOVE, 32'h0);
    send_word(OP_INSERT, 32'h1234_5678);  // refills the last cell
  endtask

  // Mixed traffic; insert bias shifts every 50 words so the queue swings
  // between empty and full. Handles favor a small pool and live entries
  // so duplicates are common.
  task automatic test_random_traffic(int n_words, int s_pct, int r_pct);
    int          ins_pct;
    int          pick;
    op_t         op;
    logic [31:0] handle;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    ins_pct = 50;
    for (int n = 0; n < n_words; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(2))
          0: ins_pct = 25;
          1: ins_pct = 55;
          default: ins_pct = 85;
        endcase
      end
      op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
      pick = $urandom_range(99);
      if (op == OP_REMOVE)               handle = $urandom;
      else if (pick < 6)                 handle = '0;
      else if (pick < 20 && held_handles.size() != 0)
        handle = held_handles[$urandom_range(held_handles.size() - 1)];
      else if (pick < 60)                handle = $urandom_range(24, 1);
      else                               handle = $urandom;
      send_word(op, handle);
    end
  endtask

  // Receiver holds off while the sender keeps offering, then the sender
  // pauses until every result is back.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sender_rest();
    hold_requests++;
    for (int n = 0; n < 30; n++)
      send_word(n % 3 == 2 ? OP_REMOVE : OP_INSERT, $urandom_range(40, 1));
    sender_rest();
    wait_results_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(400, 11, 59);
    test_backpressure();
    test_random_traffic(400, 59, 11);
    test_random_traffic(400, 0, 0);

    sender_rest();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0 && results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
src/dfq_pkg.sv
src/dfq_cell.sv
src/dedup_fifo_queue.sv
src/dfq_checker.sv
sim/tb.sv
